@@ design/twl_pkg.sv @@
// ----------------------------------------------------------------------------
// twl_pkg
// Shared types and constants of the tunable white light controller.
// ----------------------------------------------------------------------------
`default_nettype none

package twl_pkg;

   localparam int CT_W     = 16;
   localparam int PERIOD_W = 32;
   localparam int BRI_W    = 8;
   localparam int SEQ_W    = 32;
   localparam int CSR_W    = 32;
   localparam int SHARE_W  = 8;
   localparam int FAC_W    = 16;
   localparam int MIX_NUM_W  = CT_W + SHARE_W;
   localparam int PULSE_NUM_W = PERIOD_W + FAC_W;

   localparam logic [SHARE_W-1:0]  MIX_FULL        = 8'd255;
   localparam logic [CT_W-1:0]     CT_MIN_RST      = 16'd153;
   localparam logic [CT_W-1:0]     CT_MAX_RST      = 16'd500;
   localparam logic [PERIOD_W-1:0] PERIOD_RST      = 32'd1000000;
   localparam logic [CT_W-1:0]     COLOR_TEMP_RST  = 16'd326;

   // request kinds carried in req_type
   localparam logic REQ_UPDATE = 1'b0;
   localparam logic REQ_TOGGLE = 1'b1;

   typedef enum logic [1:0] {
      CSR_CT_MIN      = 2'd0,
      CSR_CT_MAX      = 2'd1,
      CSR_COOL_PERIOD = 2'd2,
      CSR_WARM_PERIOD = 2'd3
   } csr_index_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_PREP,
      ST_MIX,
      ST_MUL_LVL,
      ST_MUL_PER,
      ST_DIV,
      ST_WAIT,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic busy;
      logic done;
   } div_status_type;

endpackage

`default_nettype wire

@@ design/twl_req_if.sv @@
// ----------------------------------------------------------------------------
// twl_req_if
// Request channel: update or toggle commands for the lamp.
// ----------------------------------------------------------------------------
`default_nettype none

interface twl_req_if;
   logic        valid;
   logic        ready;
   logic        req_type;
   logic        has_on;
   logic        on_value;
   logic        has_bri;
   logic [7:0]  bri_value;
   logic        has_ct;
   logic [15:0] ct_value;

   modport source (
      output valid, req_type, has_on, on_value, has_bri, bri_value, has_ct, ct_value,
      input  ready
   );
   modport sink (
      input  valid, req_type, has_on, on_value, has_bri, bri_value, has_ct, ct_value,
      output ready
   );
endinterface

`default_nettype wire

@@ design/twl_rsp_if.sv @@
// ----------------------------------------------------------------------------
// twl_rsp_if
// Response channel: lamp state and cool/warm PWM pulse widths.
// ----------------------------------------------------------------------------
`default_nettype none

interface twl_rsp_if;
   logic        valid;
   logic        ready;
   logic        changed;
   logic        lamp_on;
   logic [7:0]  level;
   logic [15:0] mireds;
   logic [31:0] sequence_res;
   logic [31:0] cool_pulse;
   logic [31:0] warm_pulse;

   modport source (
      output valid, changed, lamp_on, level, mireds, sequence_res, cool_pulse, warm_pulse,
      input  ready
   );
   modport sink (
      input  valid, changed, lamp_on, level, mireds, sequence_res, cool_pulse, warm_pulse,
      output ready
   );
endinterface

`default_nettype wire

@@ design/twl_sdiv.sv @@
// ----------------------------------------------------------------------------
// twl_sdiv
// Bit-serial restoring divider: one quotient bit per cycle.
// ----------------------------------------------------------------------------
`default_nettype none

module twl_sdiv #(
   parameter int NUM_W = 24,
   parameter int DEN_W = 16
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   start,
   input  wire logic [NUM_W-1:0]       num,
   input  wire logic [DEN_W-1:0]       den,
   output      twl_pkg::div_status_type status,
   output      logic [NUM_W-1:0]       quot
);
   import twl_pkg::*;

   localparam int CNT_W = $clog2(NUM_W + 1);

   logic             busy_ff, busy_in;
   logic             done_ff, done_in;
   logic [CNT_W-1:0] cnt_ff, cnt_in;
   logic [DEN_W-1:0] rem_ff, rem_in;
   logic [DEN_W-1:0] den_ff, den_in;
   logic [NUM_W-1:0] quo_ff, quo_in;
   logic [DEN_W:0]   trial;
   logic             fits;

   // shift the next numerator bit into the partial remainder
   assign trial = {rem_ff, quo_ff[NUM_W-1]};
   assign fits  = trial >= {1'b0, den_ff};

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rem_in  = rem_ff;
      den_in  = den_ff;
      quo_in  = quo_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = CNT_W'(NUM_W);
         rem_in  = '0;
         den_in  = den;
         quo_in  = num;
      end else if (busy_ff) begin
         rem_in = fits ? DEN_W'(trial - {1'b0, den_ff}) : DEN_W'(trial);
         quo_in = {quo_ff[NUM_W-2:0], fits};
         cnt_in = cnt_ff - CNT_W'(1);
         if (cnt_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
      rem_ff <= rem_in;
      den_ff <= den_in;
      quo_ff <= quo_in;
   end

   assign status.busy = busy_ff;
   assign status.done = done_ff;
   assign quot        = quo_ff;

endmodule

`default_nettype wire

@@ design/tunable_white_light_controller.sv @@
// ----------------------------------------------------------------------------
// tunable_white_light_controller
// Lamp state keeper with a cool/warm PWM mixer driven by bit-serial dividers.
// ----------------------------------------------------------------------------
// Sequence: from request accept, setup, a serial mix divide (skipped when
//   ct_max <= ct_min), a level multiply and a period multiply, divide start,
//   the serial pulse divides of 48 numerator bits, and the response load.
// Flow: a new request is taken only after the last item has been loaded.
// Reset: synchronous, active high; lamp off, brightness BRI_MAX, 326 mireds,
//   counter 0, registers at their defaults; no clearing pass.
`default_nettype none

module tunable_white_light_controller #(
   parameter int BRI_MAX = 254
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   twl_req_if.sink                     req_bus,
   twl_rsp_if.source                   rsp_bus,
   input  wire logic                   csr_we,
   input  wire twl_pkg::csr_index_type csr_index,
   input  wire logic [31:0]            csr_wdata
);
   import twl_pkg::*;

   // pulse = period * share * level / (255 * BRI_MAX)
   localparam logic [CT_W-1:0]  SCALE_DIV = CT_W'(255 * BRI_MAX);
   localparam logic [BRI_W-1:0] BRI_RST   = BRI_W'(BRI_MAX);

   // configuration registers
   logic [CT_W-1:0]     ct_min_ff, ct_max_ff;
   logic [PERIOD_W-1:0] cool_period_ff, warm_period_ff;

   // lamp state
   logic                light_on_ff, light_on_in;
   logic [BRI_W-1:0]    brightness_ff, brightness_in;
   logic [CT_W-1:0]     color_temp_ff, color_temp_in;
   logic [SEQ_W-1:0]    change_count_ff, change_count_in;
   logic                changed_ff, changed_in;

   // datapath
   state_type              state_ff, state_in;
   logic [SHARE_W-1:0]     warm_share_ff, warm_share_in;
   logic [FAC_W-1:0]       cool_fac_ff, cool_fac_in;
   logic [FAC_W-1:0]       warm_fac_ff, warm_fac_in;
   logic [PULSE_NUM_W-1:0] cool_num_ff, cool_num_in;
   logic [PULSE_NUM_W-1:0] warm_num_ff, warm_num_in;

   // response register
   logic                rsp_valid_ff, rsp_valid_in;
   logic                rsp_changed_ff;
   logic                rsp_lamp_on_ff;
   logic [BRI_W-1:0]    rsp_level_ff;
   logic [CT_W-1:0]     rsp_mireds_ff;
   logic [SEQ_W-1:0]    rsp_seq_ff;
   logic [PERIOD_W-1:0] rsp_cool_ff, rsp_warm_ff;

   logic req_fire, rsp_fire, rsp_load;

   // mix prep
   logic [CT_W-1:0]      ct_clamped;
   logic [CT_W-1:0]      ct_offset;
   logic [CT_W-1:0]      ct_span;
   logic [MIX_NUM_W-1:0] mix_num;
   logic                 range_ok;
   logic                 mix_start, pulse_start;
   logic [BRI_W-1:0]     lvl;
   logic [SHARE_W-1:0]   cool_share;

   div_status_type         mix_stat, cool_stat, warm_stat;
   logic [MIX_NUM_W-1:0]   mix_quot;
   logic [PULSE_NUM_W-1:0] cool_quot, warm_quot;
   logic [PERIOD_W-1:0]    cool_pulse, warm_pulse;

   assign req_fire = req_bus.valid && req_bus.ready;
   assign rsp_fire = rsp_valid_ff && rsp_bus.ready;
   // load a finished item once the response register is free or draining
   assign rsp_load = (state_ff == ST_DONE) && (!rsp_valid_ff || rsp_bus.ready);

   assign req_bus.ready = (state_ff == ST_IDLE);

   // ---------------------------------------------------------------------
   // configuration writes
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         ct_min_ff      <= CT_MIN_RST;
         ct_max_ff      <= CT_MAX_RST;
         cool_period_ff <= PERIOD_RST;
         warm_period_ff <= PERIOD_RST;
      end else if (csr_we) begin
         case (csr_index)
            CSR_CT_MIN:      ct_min_ff      <= csr_wdata[CT_W-1:0];
            CSR_CT_MAX:      ct_max_ff      <= csr_wdata[CT_W-1:0];
            CSR_COOL_PERIOD: cool_period_ff <= csr_wdata[PERIOD_W-1:0];
            CSR_WARM_PERIOD: warm_period_ff <= csr_wdata[PERIOD_W-1:0];
            default: ;
         endcase
      end
   end

   // ---------------------------------------------------------------------
   // lamp state update, applied at request accept
   // ---------------------------------------------------------------------
   always_comb begin
      light_on_in     = light_on_ff;
      brightness_in   = brightness_ff;
      color_temp_in   = color_temp_ff;
      changed_in      = 1'b0;
      if (req_bus.req_type == REQ_TOGGLE) begin
         // toggle ignores the update fields
         light_on_in = !light_on_ff;
         changed_in  = 1'b1;
      end else begin
         if (req_bus.has_on && (req_bus.on_value != light_on_ff)) begin
            light_on_in = req_bus.on_value;
            changed_in  = 1'b1;
         end
         // a stored brightness of zero locks out brightness updates
         if (req_bus.has_bri && (brightness_ff != '0) &&
             (req_bus.bri_value != brightness_ff)) begin
            brightness_in = req_bus.bri_value;
            light_on_in   = 1'b1;
            changed_in    = 1'b1;
         end
         if (req_bus.has_ct && (req_bus.ct_value != color_temp_ff)) begin
            color_temp_in = req_bus.ct_value;
            light_on_in   = 1'b1;
            changed_in    = 1'b1;
         end
      end
      change_count_in = change_count_ff + SEQ_W'(changed_in);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         light_on_ff     <= 1'b0;
         brightness_ff   <= BRI_RST;
         color_temp_ff   <= COLOR_TEMP_RST;
         change_count_ff <= '0;
         changed_ff      <= 1'b0;
      end else if (req_fire) begin
         light_on_ff     <= light_on_in;
         brightness_ff   <= brightness_in;
         color_temp_ff   <= color_temp_in;
         change_count_ff <= change_count_in;
         changed_ff      <= changed_in;
      end
   end

   // ---------------------------------------------------------------------
   // mix setup: clamp the temperature and form (ct - ct_min) * 255
   // ---------------------------------------------------------------------
   assign range_ok = ct_max_ff > ct_min_ff;

   always_comb begin
      ct_clamped = color_temp_ff;
      if (ct_clamped < ct_min_ff) begin
         ct_clamped = ct_min_ff;
      end
      if (ct_clamped > ct_max_ff) begin
         ct_clamped = ct_max_ff;
      end
   end

   assign ct_offset = ct_clamped - ct_min_ff;
   assign ct_span   = ct_max_ff - ct_min_ff;
   // times 255 as a shift and a subtract
   assign mix_num   = {ct_offset, 8'd0} - {8'd0, ct_offset};

   assign lvl        = light_on_ff ? brightness_ff : '0;
   assign cool_share = MIX_FULL - warm_share_ff;

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_comb begin
      state_in      = state_ff;
      mix_start     = 1'b0;
      pulse_start   = 1'b0;
      warm_share_in = warm_share_ff;
      cool_fac_in   = cool_fac_ff;
      warm_fac_in   = warm_fac_ff;
      cool_num_in   = cool_num_ff;
      warm_num_in   = warm_num_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               state_in = ST_PREP;
            end
         end
         ST_PREP: begin
            // an empty or inverted range gives an all-cool mix
            if (range_ok) begin
               mix_start = 1'b1;
               state_in  = ST_MIX;
            end else begin
               warm_share_in = '0;
               state_in      = ST_MUL_LVL;
            end
         end
         ST_MIX: begin
            if (mix_stat.done) begin
               warm_share_in = mix_quot[SHARE_W-1:0];
               state_in      = ST_MUL_LVL;
            end
         end
         ST_MUL_LVL: begin
            cool_fac_in = cool_share * lvl;
            warm_fac_in = warm_share_ff * lvl;
            state_in    = ST_MUL_PER;
         end
         ST_MUL_PER: begin
            cool_num_in = cool_period_ff * cool_fac_ff;
            warm_num_in = warm_period_ff * warm_fac_ff;
            state_in    = ST_DIV;
         end
         ST_DIV: begin
            pulse_start = 1'b1;
            state_in    = ST_WAIT;
         end
         ST_WAIT: begin
            if (cool_stat.done) begin
               state_in = ST_DONE;
            end
         end
         ST_DONE: begin
            if (rsp_load) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
      warm_share_ff <= warm_share_in;
      cool_fac_ff   <= cool_fac_in;
      warm_fac_ff   <= warm_fac_in;
      cool_num_ff   <= cool_num_in;
      warm_num_ff   <= warm_num_in;
   end

   // ---------------------------------------------------------------------
   // serial dividers
   // ---------------------------------------------------------------------
   twl_sdiv #(
      .NUM_W (MIX_NUM_W),
      .DEN_W (CT_W)
   ) u_mix_div (
      .clock  (clock),
      .reset  (reset),
      .start  (mix_start),
      .num    (mix_num),
      .den    (ct_span),
      .status (mix_stat),
      .quot   (mix_quot)
   );

   twl_sdiv #(
      .NUM_W (PULSE_NUM_W),
      .DEN_W (CT_W)
   ) u_cool_div (
      .clock  (clock),
      .reset  (reset),
      .start  (pulse_start),
      .num    (cool_num_ff),
      .den    (SCALE_DIV),
      .status (cool_stat),
      .quot   (cool_quot)
   );

   twl_sdiv #(
      .NUM_W (PULSE_NUM_W),
      .DEN_W (CT_W)
   ) u_warm_div (
      .clock  (clock),
      .reset  (reset),
      .start  (pulse_start),
      .num    (warm_num_ff),
      .den    (SCALE_DIV),
      .status (warm_stat),
      .quot   (warm_quot)
   );

   // saturate each width at its period; quotients hold after done
   assign cool_pulse = (cool_quot > {{FAC_W{1'b0}}, cool_period_ff}) ?
                       cool_period_ff : cool_quot[PERIOD_W-1:0];
   assign warm_pulse = (warm_quot > {{FAC_W{1'b0}}, warm_period_ff}) ?
                       warm_period_ff : warm_quot[PERIOD_W-1:0];

   // ---------------------------------------------------------------------
   // response register
   // ---------------------------------------------------------------------
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (rsp_load) begin
         rsp_changed_ff <= changed_ff;
         rsp_lamp_on_ff <= light_on_ff;
         rsp_level_ff   <= brightness_ff;
         rsp_mireds_ff  <= color_temp_ff;
         rsp_seq_ff     <= change_count_ff;
         rsp_cool_ff    <= cool_pulse;
         rsp_warm_ff    <= warm_pulse;
      end
   end

   assign rsp_bus.valid        = rsp_valid_ff;
   assign rsp_bus.changed      = rsp_changed_ff;
   assign rsp_bus.lamp_on      = rsp_lamp_on_ff;
   assign rsp_bus.level        = rsp_level_ff;
   assign rsp_bus.mireds       = rsp_mireds_ff;
   assign rsp_bus.sequence_res = rsp_seq_ff;
   assign rsp_bus.cool_pulse   = rsp_cool_ff;
   assign rsp_bus.warm_pulse   = rsp_warm_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   // the counter advances exactly when the item changed the state
   a_count_step: assert property (@(posedge clock) disable iff (reset)
      req_fire |=> change_count_ff == $past(change_count_ff) + SEQ_W'(changed_ff))
      else $error("change counter step disagrees with changed flag");

   // both pulse dividers run in lockstep
   a_div_lockstep: assert property (@(posedge clock) disable iff (reset)
      cool_stat.done == warm_stat.done && cool_stat.busy == warm_stat.busy)
      else $error("pulse dividers out of step");

   // a loaded width never exceeds its period
   a_pulse_sat: assert property (@(posedge clock) disable iff (reset)
      rsp_load |=> rsp_cool_ff <= cool_period_ff && rsp_warm_ff <= warm_period_ff)
      else $error("pulse width above period");

   // a dark lamp drives no pulses
   a_dark_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_load && !light_on_ff |=> rsp_cool_ff == '0 && rsp_warm_ff == '0)
      else $error("nonzero pulse while lamp is off");

   // the mix quotient never exceeds full scale
   a_mix_range: assert property (@(posedge clock) disable iff (reset)
      state_ff == ST_MIX && mix_stat.done |-> mix_quot <= MIX_NUM_W'(MIX_FULL))
      else $error("mix share out of range");

endmodule

`default_nettype wire
